>>> design/segment_axis_angle_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment axis-angle block
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_AXIS_ANGLE_DEFINES_SVH
`define SEGMENT_AXIS_ANGLE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define SAS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define SAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sas_pkg.sv
// ----------------------------------------------------------------------------
// Segment axis-angle package
// Widths, angle constants, the CORDIC step table and the sideband flag type.
// ----------------------------------------------------------------------------
package sas_pkg;

    // Datapath widths of the CORDIC cells.
    localparam int XW = 36;
    localparam int ZW = 34;

    // Axis output format: Q2.14.
    localparam int AXIS_FRAC = 14;
    localparam int AXIS_ONE  = 16384;

    // Angles in degrees, Q.24.
    localparam logic signed [ZW-1:0] DEG90_Q24  = 34'sd1509949440;
    localparam logic signed [ZW-1:0] DEG180_Q24 = 34'sd3019898880;

    // Flags of one segment that travel beside the arithmetic.
    typedef struct packed {
        logic dx_neg;
        logic dy_neg;
        logic dz_pos;
        logic degen;
    } t_flags;

    // atan(2^-k) in degrees, scaled by 2^24.
    function automatic logic [29:0] f_step_deg(input logic [4:0] k);
        logic [29:0] v;
        case (k)
            5'd0:    v = 30'd754974720;
            5'd1:    v = 30'd445687602;
            5'd2:    v = 30'd235489088;
            5'd3:    v = 30'd119537938;
            5'd4:    v = 30'd60000934;
            5'd5:    v = 30'd30029717;
            5'd6:    v = 30'd15018523;
            5'd7:    v = 30'd7509720;
            5'd8:    v = 30'd3754917;
            5'd9:    v = 30'd1877466;
            5'd10:   v = 30'd938734;
            5'd11:   v = 30'd469367;
            5'd12:   v = 30'd234684;
            5'd13:   v = 30'd117342;
            5'd14:   v = 30'd58671;
            5'd15:   v = 30'd29335;
            5'd16:   v = 30'd14668;
            5'd17:   v = 30'd7334;
            5'd18:   v = 30'd3667;
            5'd19:   v = 30'd1833;
            5'd20:   v = 30'd917;
            5'd21:   v = 30'd458;
            5'd22:   v = 30'd229;
            5'd23:   v = 30'd115;
            5'd24:   v = 30'd57;
            5'd25:   v = 30'd29;
            5'd26:   v = 30'd14;
            5'd27:   v = 30'd7;
            5'd28:   v = 30'd4;
            5'd29:   v = 30'd2;
            5'd30:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> design/sas_ifs.sv
// ----------------------------------------------------------------------------
// Segment axis-angle channels
// Valid/ready interfaces for the segment request and the result.
// ----------------------------------------------------------------------------
interface sas_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    output ready);
endinterface

interface sas_out_if;
    logic               valid;
    logic               ready;
    logic        [33:0] seg_length;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic        [23:0] angle_deg;
    logic               degenerate;

    modport source (output valid, seg_length, axis_x, axis_y, angle_deg, degenerate,
                    input ready);
    modport sink   (input valid, seg_length, axis_x, axis_y, angle_deg, degenerate,
                    output ready);
endinterface

>>> design/sas_delay.sv
// ----------------------------------------------------------------------------
// Segment axis-angle delay line
// Shift line that keeps side data in step with the arithmetic pipeline.
// ----------------------------------------------------------------------------
module sas_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    generate
        if (D == 0) begin : g_none
            assign o_q = i_d;
        end else begin : g_line
            logic [W-1:0] r_tap [D];

            // Advance the whole line whenever the pipeline moves.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    for (int i = 0; i < D; i++) r_tap[i] <= '0;
                end else if (i_en) begin
                    r_tap[0] <= i_d;
                    for (int i = 1; i < D; i++) r_tap[i] <= r_tap[i-1];
                end
            end

            assign o_q = r_tap[D-1];
        end
    endgenerate

endmodule

>>> design/sas_norm_cell.sv
// ----------------------------------------------------------------------------
// Segment axis-angle normalizer cell
// One step of the joint scaling that brings the largest magnitude into [2^30, 2^31).
// ----------------------------------------------------------------------------
module sas_norm_cell #(
    parameter int LANES = 2,
    parameter int K     = 0
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [LANES-1:0][31:0] i_v,
    output logic [LANES-1:0][31:0] o_v
);

    logic [31:0] w_or;
    logic        w_sh;

    // The OR of all lanes is below a power of two exactly when the largest is.
    always_comb begin
        w_or = '0;
        for (int l = 0; l < LANES; l++) w_or = w_or | i_v[l];
    end

    generate
        if (K == 0) begin : g_right
            // A magnitude of 2^31 or more takes one truncating right shift.
            assign w_sh = w_or[31];
        end else begin : g_left
            // Shift left by K when the result still stays below 2^31.
            assign w_sh = (w_or[31 -: K+1] == '0);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                if (w_sh) o_v[l] <= (K == 0) ? (i_v[l] >> 1) : (i_v[l] << K);
                else      o_v[l] <= i_v[l];
            end
        end
    end

endmodule

>>> design/sas_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Segment axis-angle square root cell
// Decides one root bit of a restoring digit-by-digit square root.
// ----------------------------------------------------------------------------
module sas_sqrt_cell #(
    parameter int NW = 66,
    parameter int RW = 33,
    parameter int B  = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_rem,
    input  logic [RW-1:0] i_root,
    output logic [NW-1:0] o_rem,
    output logic [RW-1:0] o_root
);

    localparam int TW = (NW > RW + B + 2) ? NW : RW + B + 2;

    logic [TW-1:0] w_trial;
    logic [TW-1:0] w_rem;

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B).
    assign w_trial = (TW'(i_root) << (B + 1)) | (TW'(1) << (2 * B));
    assign w_rem   = TW'(i_rem);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_rem >= w_trial) begin
                o_rem  <= NW'(w_rem - w_trial);
                o_root <= i_root | (RW'(1) << B);
            end else begin
                o_rem  <= i_rem;
                o_root <= i_root;
            end
        end
    end

endmodule

>>> design/sas_div_cell.sv
// ----------------------------------------------------------------------------
// Segment axis-angle divider cell
// Decides one quotient bit of a restoring divide, for several lanes at once.
// ----------------------------------------------------------------------------
module sas_div_cell #(
    parameter int LANES = 2,
    parameter int NW    = 46,
    parameter int QW    = 15,
    parameter int DW    = 33,
    parameter int B     = 0
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [LANES-1:0][NW-1:0] i_rem,
    input  logic [LANES-1:0][QW-1:0] i_quo,
    input  logic [DW-1:0]          i_div,
    output logic [LANES-1:0][NW-1:0] o_rem,
    output logic [LANES-1:0][QW-1:0] o_quo,
    output logic [DW-1:0]          o_div
);

    localparam int TW = (NW > DW + B) ? NW : DW + B;

    logic [TW-1:0] w_trial;

    assign w_trial = TW'(i_div) << B;

    // Subtract the shifted divisor wherever it fits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_div <= i_div;
            for (int l = 0; l < LANES; l++) begin
                if (TW'(i_rem[l]) >= w_trial) begin
                    o_rem[l] <= NW'(TW'(i_rem[l]) - w_trial);
                    o_quo[l] <= i_quo[l] | (QW'(1) << B);
                end else begin
                    o_rem[l] <= i_rem[l];
                    o_quo[l] <= i_quo[l];
                end
            end
        end
    end

endmodule

>>> design/sas_cordic_cell.sv
// ----------------------------------------------------------------------------
// Segment axis-angle CORDIC cell
// One vectoring rotation step with the angle accumulated in degrees.
// ----------------------------------------------------------------------------
module sas_cordic_cell #(
    parameter int K = 0
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [sas_pkg::XW-1:0] i_x,
    input  logic signed [sas_pkg::XW-1:0] i_y,
    input  logic signed [sas_pkg::ZW-1:0] i_z,
    output logic signed [sas_pkg::XW-1:0] o_x,
    output logic signed [sas_pkg::XW-1:0] o_y,
    output logic signed [sas_pkg::ZW-1:0] o_z
);

    import sas_pkg::*;

    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [ZW-1:0] w_step;

    // Shifts truncate toward zero, so negative values shift as magnitudes.
    assign w_xs   = i_x[XW-1] ? -((-i_x) >>> K) : (i_x >>> K);
    assign w_ys   = i_y[XW-1] ? -((-i_y) >>> K) : (i_y >>> K);
    assign w_step = $signed(ZW'(f_step_deg(5'(K))));

    // Rotate toward the x axis, following the sign of y.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_y > 0) begin
                o_x <= i_x + w_ys;
                o_y <= i_y - w_xs;
                o_z <= i_z + w_step;
            end else begin
                o_x <= i_x - w_ys;
                o_y <= i_y + w_xs;
                o_z <= i_z - w_step;
            end
        end
    end

endmodule

>>> design/segment_axis_angle.sv
// ----------------------------------------------------------------------------
// Segment axis-angle converter
// Length and axis-angle rotation of the vector between two 3-D endpoints.
// ----------------------------------------------------------------------------
// The block accepts one segment request per clock cycle while the output is not
// stalled. Its pipeline is made of the root cells (one per root bit), the 15
// divider cells of the axis and the CORDIC cells of the angle, each a pipeline
// stage. The whole pipeline and its output register advance together, so the
// block takes a new request whenever the output register is empty or its
// result is being taken in the same cycle.
`include "segment_axis_angle_defines.svh"

module segment_axis_angle #(
    parameter int CORDIC_STAGES = 20
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sas_in_if.sink   i_seg,
    sas_out_if.source o_res
);

    import sas_pkg::*;

    localparam int ANG_DONE = 44 + CORDIC_STAGES;
    localparam int AXQ_DONE = 58;
    localparam int LEN_DONE = 37;
    localparam int T_END    = (ANG_DONE > AXQ_DONE + 1) ? ANG_DONE : AXQ_DONE + 1;

    logic w_en;
    logic w_acc;
    logic r_out_valid;

    assign w_en        = !r_out_valid || o_res.ready;
    assign i_seg.ready = w_en;
    assign w_acc       = i_seg.valid && w_en;

    // Differences of the endpoints, exact in 33 bits.
    logic signed [32:0] r_dx, r_dy, r_dz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx <= $signed({i_seg.end_x[31], i_seg.end_x})
                  - $signed({i_seg.start_x[31], i_seg.start_x});
            r_dy <= $signed({i_seg.end_y[31], i_seg.end_y})
                  - $signed({i_seg.start_y[31], i_seg.start_y});
            r_dz <= $signed({i_seg.end_z[31], i_seg.end_z})
                  - $signed({i_seg.start_z[31], i_seg.start_z});
        end
    end

    logic [31:0] w_mx, w_my, w_mz;
    t_flags      w_flags;

    assign w_mx = r_dx[32] ? 32'(-r_dx) : r_dx[31:0];
    assign w_my = r_dy[32] ? 32'(-r_dy) : r_dy[31:0];
    assign w_mz = r_dz[32] ? 32'(-r_dz) : r_dz[31:0];

    assign w_flags.dx_neg = r_dx[32];
    assign w_flags.dy_neg = r_dy[32];
    assign w_flags.dz_pos = !r_dz[32] && (r_dz != '0);
    assign w_flags.degen  = (r_dy == '0) && (r_dz == '0);

    // Length: exact sum of squares, then the root cells.
    logic [63:0] r_sq_x, r_sq_y, r_sq_z;
    logic [65:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_x <= w_mx * w_mx;
            r_sq_y <= w_my * w_my;
            r_sq_z <= w_mz * w_mz;
            r_sum  <= 66'(r_sq_x) + 66'(r_sq_y) + 66'(r_sq_z);
        end
    end

    logic [65:0] w_lrem  [34];
    logic [32:0] w_lroot [34];

    assign w_lrem[0]  = r_sum;
    assign w_lroot[0] = '0;

    generate
        for (genvar j = 0; j < 33; j++) begin : g_lsqrt
            sas_sqrt_cell #(.NW(66), .RW(33), .B(32 - j)) u_cell (
                .i_clk (i_clk), .i_en (w_en),
                .i_rem (w_lrem[j]), .i_root (w_lroot[j]),
                .o_rem (w_lrem[j+1]), .o_root (w_lroot[j+1])
            );
        end
    endgenerate

    logic [33:0] r_len;
    logic [33:0] w_len_end;

    // Round to nearest: add one when the remainder exceeds the root.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_len <= 34'(w_lroot[33]) + 34'(w_lrem[33] > 66'(w_lroot[33]));
        end
    end

    sas_delay #(.W(34), .D(T_END - LEN_DONE)) u_len_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_d (r_len), .o_q (w_len_end)
    );

    // Scaling of (dy, dz) for the axis and of (dx, dy, dz) for the angle.
    logic [1:0][31:0] w_an [7];
    logic [2:0][31:0] w_gn [7];

    assign w_an[0] = {w_mz, w_my};
    assign w_gn[0] = {w_mz, w_my, w_mx};

    generate
        for (genvar j = 0; j < 6; j++) begin : g_norm
            sas_norm_cell #(.LANES(2), .K((j == 0) ? 0 : (32 >> j))) u_axis (
                .i_clk (i_clk), .i_en (w_en), .i_v (w_an[j]), .o_v (w_an[j+1])
            );
            sas_norm_cell #(.LANES(3), .K((j == 0) ? 0 : (32 >> j))) u_ang (
                .i_clk (i_clk), .i_en (w_en), .i_v (w_gn[j]), .o_v (w_gn[j+1])
            );
        end
    endgenerate

    // Sums of squares of the scaled pairs.
    logic [63:0] r_ay2, r_az2, r_gy2, r_gz2;
    logic [62:0] r_asum, r_gsum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ay2  <= w_an[6][0] * w_an[6][0];
            r_az2  <= w_an[6][1] * w_an[6][1];
            r_gy2  <= w_gn[6][1] * w_gn[6][1];
            r_gz2  <= w_gn[6][2] * w_gn[6][2];
            r_asum <= 63'(r_ay2 + r_az2);
            r_gsum <= 63'(r_gy2 + r_gz2);
        end
    end

    logic [62:0] w_arem  [33];
    logic [31:0] w_aroot [33];
    logic [62:0] w_grem  [33];
    logic [31:0] w_groot [33];

    assign w_arem[0]  = r_asum;
    assign w_aroot[0] = '0;
    assign w_grem[0]  = r_gsum;
    assign w_groot[0] = '0;

    generate
        for (genvar j = 0; j < 32; j++) begin : g_rsqrt
            sas_sqrt_cell #(.NW(63), .RW(32), .B(31 - j)) u_axis (
                .i_clk (i_clk), .i_en (w_en),
                .i_rem (w_arem[j]), .i_root (w_aroot[j]),
                .o_rem (w_arem[j+1]), .o_root (w_aroot[j+1])
            );
            sas_sqrt_cell #(.NW(63), .RW(32), .B(31 - j)) u_ang (
                .i_clk (i_clk), .i_en (w_en),
                .i_rem (w_grem[j]), .i_root (w_groot[j]),
                .o_rem (w_grem[j+1]), .o_root (w_groot[j+1])
            );
        end
    endgenerate

    logic [32:0] r_ar, r_gr;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ar <= 33'(w_aroot[32]) + 33'(w_arem[32] > 63'(w_aroot[32]));
            r_gr <= 33'(w_groot[32]) + 33'(w_grem[32] > 63'(w_groot[32]));
        end
    end

    // Side data carried to the end of the root cells.
    logic [1:0][31:0] w_an_d;
    logic [31:0]      w_tx_d;
    t_flags           w_flags_mid;
    t_flags           w_flags_end;

    sas_delay #(.W(64), .D(35)) u_num_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_d (w_an[6]), .o_q (w_an_d)
    );
    sas_delay #(.W(32), .D(35)) u_tx_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_d (w_gn[6][0]), .o_q (w_tx_d)
    );
    sas_delay #(.W($bits(t_flags)), .D(41)) u_flag_dly0 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_d (w_flags), .o_q (w_flags_mid)
    );
    sas_delay #(.W($bits(t_flags)), .D(T_END - 42)) u_flag_dly1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_d (w_flags_mid),
        .o_q (w_flags_end)
    );

    // Axis: numerators c * 2^14 + r/2, then the divider cells.
    logic [1:0][45:0] w_drem [16];
    logic [1:0][14:0] w_dquo [16];
    logic [32:0]      w_ddiv [16];
    logic [1:0][45:0] r_num;
    logic [32:0]      r_dv;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num[0] <= (46'(w_an_d[0]) << AXIS_FRAC) + 46'(r_ar >> 1);
            r_num[1] <= (46'(w_an_d[1]) << AXIS_FRAC) + 46'(r_ar >> 1);
            r_dv     <= r_ar;
        end
    end

    assign w_drem[0] = r_num;
    assign w_dquo[0] = '0;
    assign w_ddiv[0] = r_dv;

    generate
        for (genvar j = 0; j < 15; j++) begin : g_div
            sas_div_cell #(.LANES(2), .NW(46), .QW(15), .DW(33), .B(14 - j)) u_cell (
                .i_clk (i_clk), .i_en (w_en),
                .i_rem (w_drem[j]), .i_quo (w_dquo[j]), .i_div (w_ddiv[j]),
                .o_rem (w_drem[j+1]), .o_quo (w_dquo[j+1]), .o_div (w_ddiv[j+1])
            );
        end
    endgenerate

    logic [1:0][14:0] w_quo_end;

    sas_delay #(.W(30), .D(T_END - AXQ_DONE)) u_quo_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_d (w_dquo[15]),
        .o_q (w_quo_end)
    );

    // Angle: a vector in the left half plane first turns by 90 degrees.
    logic signed [XW-1:0] w_cx [CORDIC_STAGES+1];
    logic signed [XW-1:0] w_cy [CORDIC_STAGES+1];
    logic signed [ZW-1:0] w_cz [CORDIC_STAGES+1];
    logic signed [XW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_flags_mid.dx_neg && (w_tx_d != '0)) begin
                r_cx <= $signed(XW'(r_gr));
                r_cy <= $signed(XW'(w_tx_d));
                r_cz <= DEG90_Q24;
            end else begin
                r_cx <= $signed(XW'(w_tx_d));
                r_cy <= $signed(XW'(r_gr));
                r_cz <= '0;
            end
        end
    end

    assign w_cx[0] = r_cx;
    assign w_cy[0] = r_cy;
    assign w_cz[0] = r_cz;

    generate
        for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
            sas_cordic_cell #(.K(j % 32)) u_cell (
                .i_clk (i_clk), .i_en (w_en),
                .i_x (w_cx[j]), .i_y (w_cy[j]), .i_z (w_cz[j]),
                .o_x (w_cx[j+1]), .o_y (w_cy[j+1]), .o_z (w_cz[j+1])
            );
        end
    endgenerate

    // Clamp to [0, 180] degrees and round Q.24 to Q.16.
    logic [ZW-1:0] w_zc;
    logic [23:0]   r_ang;
    logic [23:0]   w_ang_end;

    always_comb begin
        if (w_cz[CORDIC_STAGES] < 0)               w_zc = '0;
        else if (w_cz[CORDIC_STAGES] > DEG180_Q24) w_zc = DEG180_Q24;
        else                                       w_zc = w_cz[CORDIC_STAGES];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_ang <= 24'((w_zc + ZW'(128)) >> 8);
    end

    sas_delay #(.W(24), .D(T_END - ANG_DONE)) u_ang_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_d (r_ang), .o_q (w_ang_end)
    );

    // Request valid travels with the data.
    logic w_v_end;

    sas_delay #(.W(1), .D(T_END)) u_vld_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_d (w_acc), .o_q (w_v_end)
    );

    // Output register: signs applied, degenerate segments zeroed.
    logic [33:0]        r_len_o;
    logic signed [15:0] r_ax, r_ay;
    logic [23:0]        r_ang_o;
    logic               r_degen;
    logic signed [15:0] w_qy, w_qz;

    assign w_qy = $signed({1'b0, w_quo_end[0]});
    assign w_qz = $signed({1'b0, w_quo_end[1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_v_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_len_o <= w_len_end;
            r_degen <= w_flags_end.degen;
            if (w_flags_end.degen) begin
                r_ax    <= '0;
                r_ay    <= '0;
                r_ang_o <= '0;
            end else begin
                r_ax    <= w_flags_end.dz_pos ? -w_qz : w_qz;
                r_ay    <= w_flags_end.dy_neg ? -w_qy : w_qy;
                r_ang_o <= w_ang_end;
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.seg_length = r_len_o;
    assign o_res.axis_x     = r_ax;
    assign o_res.axis_y     = r_ay;
    assign o_res.angle_deg  = r_ang_o;
    assign o_res.degenerate = r_degen;

    // A stalled result holds the whole pipeline, input included.
    `SAS_ASSERT_IMPLY(a_stall_blocks_input, i_clk, i_rst_n, o_res.valid && !o_res.ready, !i_seg.ready, "input ready while output stalled")

    // A degenerate segment carries no axis and no angle.
    `SAS_ASSERT_IMPLY(a_degen_zero, i_clk, i_rst_n, o_res.valid && o_res.degenerate, (o_res.axis_x == 16'sd0) && (o_res.axis_y == 16'sd0) && (o_res.angle_deg == 24'd0), "degenerate result with nonzero axis or angle")

    // The axis never exceeds unit magnitude.
    `SAS_ASSERT_IMPLY(a_axis_unit, i_clk, i_rst_n, o_res.valid, (o_res.axis_x <= AXIS_ONE) && (o_res.axis_x >= -AXIS_ONE) && (o_res.axis_y <= AXIS_ONE) && (o_res.axis_y >= -AXIS_ONE), "axis component beyond unit magnitude")

endmodule

>>> tb/tb_segment_axis_angle.sv
// ----------------------------------------------------------------------------
// Segment axis-angle testbench
// Streams segments through the block under random and directed flow control.
// Each result is compared with a bit-exact software predictor of the
// length, rotation axis and CORDIC angle.
// ----------------------------------------------------------------------------
module tb_segment_axis_angle;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES     = 20;
    localparam int DRAIN_WAIT = 100;
    localparam int STALL_LEN  = 300;
    localparam int WDOG_LIMIT = 3000;

    // Expected result of one segment.
    typedef struct {
        logic [33:0]        seg_length;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic [23:0]        angle_deg;
        logic               degenerate;
    } t_seg_result;

    // atan(2^-k) in degrees, Q.24.
    localparam longint ATAN_DEG[32] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
        115, 57, 29, 14, 7, 4, 2, 1, 0
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    sas_in_if  seg_if ();
    sas_out_if res_if ();

    segment_axis_angle #(.CORDIC_STAGES(STAGES)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if.sink),
        .o_res   (res_if.source)
    );

    always #5 i_clk = ~i_clk;

    t_seg_result pending_results[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          stall_req = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    bit          timed_out = 1'b0;

    // Rounded integer square root of a value below 2^70.
    function automatic longint unsigned root_rnd(input logic [127:0] n);
        logic [127:0] res;
        logic [127:0] t;
        res = '0;
        for (int b = 34; b >= 0; b--) begin
            t = res | (128'd1 << b);
            if (t * t <= n) res = t;
        end
        if (n > res * res + res) res = res + 1;
        return res[63:0];
    endfunction

    // Shift bringing m into [2^30, 2^31); -1 stands for one right shift.
    function automatic int norm_amount(input longint unsigned m);
        int s;
        s = 0;
        if (m == 0) return 0;
        if (m >= 64'd2147483648) return -1;
        while (m < 64'd1073741824) begin
            m = m << 1;
            s++;
        end
        return s;
    endfunction

    function automatic longint unsigned scale_by(input longint unsigned m, input int s);
        return (s < 0) ? (m >> 1) : (m << s);
    endfunction

    function automatic longint shift_toward_zero(input longint v, input int k);
        return (v < 0) ? -longint'(longint'(-v) >>> k) : (v >>> k);
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Predicts length, axis and angle of the segment from start to end.
    function automatic t_seg_result predict_rotation(
        input logic signed [31:0] sx, sy, sz, ex, ey, ez);
        t_seg_result       r;
        longint            dx, dy, dz, x, y, z, xs, ys;
        longint unsigned   mx, my, mz, ny, nz, rad, qy, qz, m3, ang;
        logic [127:0]      sum_sq;
        int                s;
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        dz = longint'(ez) - longint'(sz);
        mx = magnitude(dx);
        my = magnitude(dy);
        mz = magnitude(dz);
        sum_sq = 128'(mx) * 128'(mx) + 128'(my) * 128'(my) + 128'(mz) * 128'(mz);
        r.seg_length = 34'(root_rnd(sum_sq));
        r.degenerate = (dy == 0 && dz == 0);
        r.axis_x = '0;
        r.axis_y = '0;
        r.angle_deg = '0;
        if (!r.degenerate) begin
            // Axis from the jointly scaled (dy, dz) pair.
            s = norm_amount(my > mz ? my : mz);
            ny = scale_by(my, s);
            nz = scale_by(mz, s);
            rad = root_rnd(128'(ny * ny + nz * nz));
            qy = (ny * 16384 + rad / 2) / rad;
            qz = (nz * 16384 + rad / 2) / rad;
            r.axis_x = (dz > 0) ? -16'(qz) : 16'(qz);
            r.axis_y = (dy < 0) ? -16'(qy) : 16'(qy);

            // Angle: all three components scaled together, then CORDIC.
            m3 = mx > my ? mx : my;
            if (mz > m3) m3 = mz;
            s = norm_amount(m3);
            x = longint'(scale_by(mx, s));
            if (dx < 0) x = -x;
            ny = scale_by(my, s);
            nz = scale_by(mz, s);
            y = longint'(root_rnd(128'(ny * ny + nz * nz)));
            z = 0;
            if (x < 0) begin
                xs = x;
                x = y;
                y = -xs;
                z = 64'd1509949440;
            end
            for (int i = 0; i < STAGES; i++) begin
                xs = shift_toward_zero(x, i % 32);
                ys = shift_toward_zero(y, i % 32);
                if (y > 0) begin
                    x += ys; y -= xs; z += ATAN_DEG[i % 32];
                end else begin
                    x -= ys; y += xs; z -= ATAN_DEG[i % 32];
                end
            end
            if (z < 0) z = 0;
            if (z > 64'd3019898880) z = 64'd3019898880;
            ang = (longint'(z) + 128) >> 8;
            if (ang > 11796480) ang = 11796480;
            r.angle_deg = 24'(ang);
        end
        return r;
    endfunction

    // Sends one segment request, with a random gap first.
    task automatic send_segment(input logic signed [31:0] sx, sy, sz, ex, ey, ez);
        if ($urandom_range(99) < send_idle_pct) begin
            seg_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        seg_if.valid   <= 1'b1;
        seg_if.start_x <= sx;
        seg_if.start_y <= sy;
        seg_if.start_z <= sz;
        seg_if.end_x   <= ex;
        seg_if.end_y   <= ey;
        seg_if.end_z   <= ez;
        do @(posedge i_clk); while (!seg_if.ready);
        pending_results.push_back(predict_rotation(sx, sy, sz, ex, ey, ez));
    endtask

    task automatic finish_sending();
        seg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random segment: full range, small coordinates, randomly scaled, axis-aligned or tiny r.
    task automatic send_random_segment();
        logic signed [31:0] c[6];
        int                 kind;
        kind = $urandom_range(9);
        foreach (c[i]) c[i] = $urandom;
        case (kind)
            0, 1, 2, 3: ;
            4, 5: foreach (c[i]) c[i] = $signed($urandom_range(2000)) - 1000;
            6: begin
                c[4] = c[1];
                c[5] = c[2];
            end
            7: begin
                c[4] = c[1] + $signed($urandom_range(2)) - 1;
                c[5] = c[2] + $signed($urandom_range(2)) - 1;
            end
            default: foreach (c[i]) c[i] = c[i] >>> $urandom_range(31);
        endcase
        send_segment(c[0], c[1], c[2], c[3], c[4], c[5]);
    endtask

    // Receiver flow control, with an optional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (stall_req) begin
                stall_req = 1'b0;
                stall_left = STALL_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_seg_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result: no request pending");
            end else begin
                want = pending_results.pop_front();
                if (res_if.seg_length !== want.seg_length || res_if.axis_x !== want.axis_x ||
                    res_if.axis_y !== want.axis_y || res_if.angle_deg !== want.angle_deg ||
                    res_if.degenerate !== want.degenerate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: exp len=%0d ax=%0d ay=%0d ang=%0d dg=%0b, got len=%0d ax=%0d ay=%0d ang=%0d dg=%0b",
                                 want.seg_length, want.axis_x, want.axis_y, want.angle_deg,
                                 want.degenerate, res_if.seg_length, res_if.axis_x,
                                 res_if.axis_y, res_if.angle_deg, res_if.degenerate);
                end
            end
        end
    end

    // Watchdog: cycles with work outstanding but no request moving.
    always @(posedge i_clk) begin
        if ((seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready) ||
            (!seg_if.valid && pending_results.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_for_results();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Extremes, each axis direction, the degenerate and tiny-r cases.
    task automatic test_directed();
        send_segment(0, 0, 0, 0, 0, 0);
        send_segment(32'sh80000000, 32'sh80000000, 32'sh80000000,
                     32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_segment(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                     32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_segment(0, 0, 0, 32'sh00010000, 0, 0);
        send_segment(0, 0, 0, -32'sh00010000, 0, 0);
        send_segment(0, 0, 0, 0, 32'sh00010000, 0);
        send_segment(0, 0, 0, 0, -32'sh00010000, 0);
        send_segment(0, 0, 0, 0, 0, 32'sh00010000);
        send_segment(0, 0, 0, 0, 0, -32'sh00010000);
        send_segment(0, 0, 0, 1, 1, 1);
        send_segment(0, 0, 0, -1, -1, -1);
        // Tiny r beside a huge dx, both signs.
        send_segment(32'sh80000000, 0, 0, 32'sh7fffffff, 1, 0);
        send_segment(32'sh7fffffff, 0, 0, 32'sh80000000, 0, -1);
        send_segment(32'sh80000000, 5, 5, 32'sh7fffffff, 5, 5);
        send_segment(0, 32'sh80000000, 0, 0, 32'sh7fffffff, 32'sh7fffffff);
        send_segment(0, 0, 0, 32'sh00030000, 32'sh00040000, 32'sh00050000);
        finish_sending();
        wait_for_results();
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_random_segment();
        finish_sending();
    endtask

    // Long receiver hold-off while requests keep coming, so the pipe fills.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req = 1'b1;
        repeat (120) send_random_segment();
        finish_sending();
        wait_for_results();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        seg_if.valid   <= 1'b0;
        seg_if.start_x <= '0;
        seg_if.start_y <= '0;
        seg_if.start_z <= '0;
        seg_if.end_x   <= '0;
        seg_if.end_y   <= '0;
        seg_if.end_z   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(270, 37, 62);
        wait_for_results();
        test_random(270, 62, 37);
        test_random(270, 0, 0);
        test_backpressure();

        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
